FILE: rtl/lz_literal_match_copy_engine_core_macros.svh
// Assertion helpers for the checker file of this block.
`ifndef LZ_LITERAL_MATCH_COPY_ENGINE_CORE_MACROS_SVH
`define LZ_LITERAL_MATCH_COPY_ENGINE_CORE_MACROS_SVH

// The consequent must hold in the cycle after the antecedent, outside of reset.
`define LZC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after reset is sampled.
`define LZC_ASSERT_AFTER_RESET(lbl, clk, rst_n, cons, msg) \
    lbl: assert property (@(posedge clk) !(rst_n) |=> (cons)) else $error(msg);

`endif

FILE: rtl/lzc_pkg.sv
`default_nettype none

package lzc_pkg;

    localparam int DEF_ELEMENT_BITS  = 8;
    localparam int DEF_SOURCE_DEPTH  = 65536;
    localparam int DEF_HISTORY_DEPTH = 65536;

    localparam int CMD_W   = 2;
    localparam int FIELD_W = 16;
    localparam int BYTE_W  = 8;
    localparam int STEP_W  = 4;

    // Command queue entry without the element: cmd, addr, length, length mod
    // history depth, offset mod history depth.
    localparam int Q_FIX_W = CMD_W + 4 * FIELD_W;
    localparam int Q_DEPTH = 2;
    localparam int RES_W   = BYTE_W + FIELD_W;
    localparam int RES_DEPTH = 2;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_LITERAL = 2'd1,
        CMD_MATCH   = 2'd2,
        CMD_READ    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        F_IDLE,
        F_REDUCE,
        F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_COPY,
        B_DRAIN,
        B_RDWAIT,
        B_RESULT
    } t_back_state;

    // Number of restoring subtract steps that bring a 16-bit value below d.
    // Power-of-two depths reduce with a mask and need none.
    function automatic int red_steps(input int unsigned d);
        int n;
        n = 0;
        if ((d & (d - 1)) != 0) begin
            for (int k = 0; k < 16; k++) begin
                if ((64'(d) << k) <= 64'd65535) begin
                    n = k + 1;
                end
            end
        end
        return n;
    endfunction

    function automatic logic [FIELD_W-1:0] mod_fast(input logic [FIELD_W-1:0] x,
                                                    input int unsigned d);
        logic [FIELD_W-1:0] r;
        r = x;
        if (((d & (d - 1)) == 0) && (d <= 65536)) begin
            r = x & FIELD_W'(d - 1);
        end
        return r;
    endfunction

    function automatic logic [FIELD_W-1:0] mod_step(input logic [FIELD_W-1:0] x,
                                                    input int unsigned d,
                                                    input logic [STEP_W-1:0] k);
        logic [31:0]        dk;
        logic [FIELD_W-1:0] r;
        dk = 32'(d) << k;
        r  = x;
        if ((dk <= 32'h0000_FFFF) && ({16'd0, x} >= dk)) begin
            r = x - dk[FIELD_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/lz_literal_match_copy_engine_core.sv
// Element-wise LZ copy engine: loads literal bytes into a source memory and
// copies literals and back-references into a history memory.
// Command channel: a beat moves on a rising edge with push high and full low.
// It carries cmd (load, literal copy, match copy, read), addr, data,
// copy_length and match_offset. Every command yields exactly one result beat.
// Result channel: the oldest result sits on o_read_data / o_write_pos while
// empty is low and leaves on an edge with pop high.
// A front stage reduces addresses, lengths and offsets modulo the memory
// depths (with a mask for power-of-two depths, by restoring subtract steps
// otherwise) and hands commands through a two-entry queue to the back stage.
// The back stage moves one element per cycle through the memories while it
// copies, then passes through a drain state to the result state; a load goes
// straight to the result state and a read waits for the memory data first.
// Reset clears the write pointer and both queues; memory contents are kept
// and are undefined until written. When pop is held low the result queue
// fills, the back stage waits, and full rises once the command queue is full.
`default_nettype none

module lz_literal_match_copy_engine_core #(
    parameter int ELEMENT_BITS  = lzc_pkg::DEF_ELEMENT_BITS,
    parameter int SOURCE_DEPTH  = lzc_pkg::DEF_SOURCE_DEPTH,
    parameter int HISTORY_DEPTH = lzc_pkg::DEF_HISTORY_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [lzc_pkg::CMD_W-1:0]    i_cmd,
    input  logic [lzc_pkg::FIELD_W-1:0]  i_addr,
    input  logic [lzc_pkg::BYTE_W-1:0]   i_data,
    input  logic [lzc_pkg::FIELD_W-1:0]  i_copy_length,
    input  logic [lzc_pkg::FIELD_W-1:0]  i_match_offset,
    output logic                         empty,
    input  logic                         pop,
    output logic [lzc_pkg::BYTE_W-1:0]   o_read_data,
    output logic [lzc_pkg::FIELD_W-1:0]  o_write_pos
);

    import lzc_pkg::*;

    localparam int QW = Q_FIX_W + ELEMENT_BITS;

    logic          q_push, q_full, q_pop, q_empty;
    logic [QW-1:0] q_wdata, q_rdata;
    logic          res_push, res_full;
    logic [RES_W-1:0] res_wdata, res_rdata;

    lzc_front #(
        .ELEMENT_BITS  (ELEMENT_BITS),
        .SOURCE_DEPTH  (SOURCE_DEPTH),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_cmd          (i_cmd),
        .i_addr         (i_addr),
        .i_data         (i_data),
        .i_copy_length  (i_copy_length),
        .i_match_offset (i_match_offset),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_q_data       (q_wdata)
    );

    lzc_fifo #(
        .WIDTH (QW),
        .DEPTH (Q_DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    lzc_back #(
        .ELEMENT_BITS  (ELEMENT_BITS),
        .SOURCE_DEPTH  (SOURCE_DEPTH),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (!q_empty),
        .i_q_data   (q_rdata),
        .o_q_pop    (q_pop),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_res_data (res_wdata)
    );

    lzc_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_wdata),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_rdata),
        .o_empty (empty)
    );

    assign o_read_data = res_rdata[RES_W-1 -: BYTE_W];
    assign o_write_pos = res_rdata[FIELD_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/lzc_ram.sv
`default_nettype none

module lzc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_wa,
    input  logic [WIDTH-1:0] i_wd,
    input  logic             i_re,
    input  logic [AW-1:0]    i_ra,
    output logic [WIDTH-1:0] o_rd
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd;

    // Read-before-write: a read at the address being written returns old data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        if (i_re) begin
            r_rd <= r_mem[i_ra];
        end
    end

    assign o_rd = r_rd;

endmodule

`default_nettype wire

FILE: rtl/lzc_fifo.sv
`default_nettype none

module lzc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, n_wr;
    logic [PW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = do_push ? ptr_inc(r_wr) : r_wr;
        n_rd  = do_pop ? ptr_inc(r_rd) : r_rd;
        n_cnt = r_cnt;
        unique case ({do_push, do_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/lzc_front.sv
`default_nettype none

module lzc_front #(
    parameter int ELEMENT_BITS  = 8,
    parameter int SOURCE_DEPTH  = 65536,
    parameter int HISTORY_DEPTH = 65536
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_push,
    output logic                                      o_full,
    input  logic [lzc_pkg::CMD_W-1:0]                 i_cmd,
    input  logic [lzc_pkg::FIELD_W-1:0]               i_addr,
    input  logic [lzc_pkg::BYTE_W-1:0]                i_data,
    input  logic [lzc_pkg::FIELD_W-1:0]               i_copy_length,
    input  logic [lzc_pkg::FIELD_W-1:0]               i_match_offset,
    input  logic                                      i_q_full,
    output logic                                      o_q_push,
    output logic [lzc_pkg::Q_FIX_W+ELEMENT_BITS-1:0]  o_q_data
);

    import lzc_pkg::*;

    localparam int S_STEPS = red_steps(SOURCE_DEPTH);
    localparam int H_STEPS = red_steps(HISTORY_DEPTH);
    localparam int NSTEPS  = (S_STEPS > H_STEPS) ? S_STEPS : H_STEPS;
    localparam logic [STEP_W-1:0] LAST_STEP = (NSTEPS > 0) ? STEP_W'(NSTEPS - 1) : '0;

    t_front_state            r_state, n_state;
    logic [STEP_W-1:0]       r_step, n_step;
    t_cmd                    r_cmd, n_cmd;
    logic [FIELD_W-1:0]      r_addr, n_addr;
    logic [ELEMENT_BITS-1:0] r_data, n_data;
    logic [FIELD_W-1:0]      r_len, n_len;
    logic [FIELD_W-1:0]      r_lenm, n_lenm;
    logic [FIELD_W-1:0]      r_off, n_off;
    int unsigned             held_addr_depth;
    int unsigned             in_addr_depth;

    // Reads address the history memory, everything else the source memory.
    assign held_addr_depth = (r_cmd == CMD_READ) ? HISTORY_DEPTH : SOURCE_DEPTH;
    assign in_addr_depth   = (t_cmd'(i_cmd) == CMD_READ) ? HISTORY_DEPTH : SOURCE_DEPTH;

    assign o_q_data = {r_cmd, r_addr, r_len, r_lenm, r_off, r_data};

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_cmd    = r_cmd;
        n_addr   = r_addr;
        n_data   = r_data;
        n_len    = r_len;
        n_lenm   = r_lenm;
        n_off    = r_off;
        o_q_push = 1'b0;
        o_full   = 1'b1;

        unique case (r_state)
            F_IDLE: begin
                o_full = 1'b0;
            end
            F_REDUCE: begin
                n_addr = mod_step(r_addr, held_addr_depth, r_step);
                n_lenm = mod_step(r_lenm, HISTORY_DEPTH, r_step);
                n_off  = mod_step(r_off, HISTORY_DEPTH, r_step);
                if (r_step == '0) begin
                    n_state = F_PUSH;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            F_PUSH: begin
                if (!i_q_full) begin
                    o_q_push = 1'b1;
                    o_full   = 1'b0;
                    n_state  = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase

        if (i_push && !o_full) begin
            n_cmd   = t_cmd'(i_cmd);
            n_addr  = mod_fast(i_addr, in_addr_depth);
            n_data  = ELEMENT_BITS'(i_data);
            n_len   = i_copy_length;
            n_lenm  = mod_fast(i_copy_length, HISTORY_DEPTH);
            n_off   = mod_fast(i_match_offset, HISTORY_DEPTH);
            n_step  = LAST_STEP;
            n_state = (NSTEPS > 0) ? F_REDUCE : F_PUSH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_addr <= n_addr;
        r_data <= n_data;
        r_len  <= n_len;
        r_lenm <= n_lenm;
        r_off  <= n_off;
    end

endmodule

`default_nettype wire

FILE: rtl/lzc_back.sv
`default_nettype none

module lzc_back #(
    parameter int ELEMENT_BITS  = 8,
    parameter int SOURCE_DEPTH  = 65536,
    parameter int HISTORY_DEPTH = 65536
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_q_valid,
    input  logic [lzc_pkg::Q_FIX_W+ELEMENT_BITS-1:0]  i_q_data,
    output logic                                      o_q_pop,
    input  logic                                      i_res_full,
    output logic                                      o_res_push,
    output logic [lzc_pkg::RES_W-1:0]                 o_res_data
);

    import lzc_pkg::*;

    localparam int QW  = Q_FIX_W + ELEMENT_BITS;
    localparam int SAW = $clog2(SOURCE_DEPTH);
    localparam int HAW = $clog2(HISTORY_DEPTH);
    localparam int HW1 = HAW + 1;

    t_back_state             r_state, n_state;
    logic [HAW-1:0]          r_wp, n_wp;
    logic                    r_is_match, n_is_match;
    logic [SAW-1:0]          r_src_s, n_src_s;
    logic [HAW-1:0]          r_src_h, n_src_h;
    logic [HAW-1:0]          r_dst, n_dst;
    logic [FIELD_W-1:0]      r_cnt, n_cnt;
    logic                    r_wv, n_wv;
    logic [HAW-1:0]          r_wa, n_wa;
    logic                    r_fwd, n_fwd;
    logic [ELEMENT_BITS-1:0] r_fwd_d, n_fwd_d;
    logic [ELEMENT_BITS-1:0] r_rd, n_rd;

    t_cmd                    e_cmd;
    logic [FIELD_W-1:0]      e_addr;
    logic [FIELD_W-1:0]      e_len;
    logic [FIELD_W-1:0]      e_lenm;
    logic [FIELD_W-1:0]      e_off;
    logic [ELEMENT_BITS-1:0] e_data;

    logic                    src_we, src_re;
    logic [SAW-1:0]          src_ra;
    logic [ELEMENT_BITS-1:0] src_q;
    logic                    hist_re;
    logic [HAW-1:0]          hist_ra;
    logic [ELEMENT_BITS-1:0] hist_q;
    logic [ELEMENT_BITS-1:0] hist_wd;

    logic [HW1-1:0]          wp_sum;
    logic [HAW-1:0]          wp_next;
    logic [HW1-1:0]          back_diff;
    logic [HAW-1:0]          match_src;

    function automatic logic [HAW-1:0] inc_h(input logic [HAW-1:0] x);
        return (x == HAW'(HISTORY_DEPTH - 1)) ? '0 : x + 1'b1;
    endfunction

    function automatic logic [SAW-1:0] inc_s(input logic [SAW-1:0] x);
        return (x == SAW'(SOURCE_DEPTH - 1)) ? '0 : x + 1'b1;
    endfunction

    assign e_cmd  = t_cmd'(i_q_data[QW-1 -: CMD_W]);
    assign e_addr = i_q_data[QW-CMD_W-1 -: FIELD_W];
    assign e_len  = i_q_data[QW-CMD_W-FIELD_W-1 -: FIELD_W];
    assign e_lenm = i_q_data[QW-CMD_W-2*FIELD_W-1 -: FIELD_W];
    assign e_off  = i_q_data[QW-CMD_W-3*FIELD_W-1 -: FIELD_W];
    assign e_data = i_q_data[ELEMENT_BITS-1:0];

    // Length and offset arrive already reduced below the history depth.
    assign wp_sum    = {1'b0, r_wp} + HW1'(e_lenm);
    assign wp_next   = (wp_sum >= HW1'(HISTORY_DEPTH)) ?
                       HAW'(wp_sum - HW1'(HISTORY_DEPTH)) : HAW'(wp_sum);
    assign back_diff = {1'b0, r_wp} - HW1'(e_off);
    assign match_src = back_diff[HAW] ?
                       HAW'(back_diff + HW1'(HISTORY_DEPTH)) : HAW'(back_diff);

    // A match whose source is the element written in the same cycle takes the
    // forwarded value, since the memory returns the old contents then.
    assign hist_wd = r_is_match ? (r_fwd ? r_fwd_d : hist_q) : src_q;

    assign o_res_data = {BYTE_W'(r_rd), FIELD_W'(r_wp)};

    always_comb begin
        n_state    = r_state;
        n_wp       = r_wp;
        n_is_match = r_is_match;
        n_src_s    = r_src_s;
        n_src_h    = r_src_h;
        n_dst      = r_dst;
        n_cnt      = r_cnt;
        n_wv       = 1'b0;
        n_wa       = r_wa;
        n_rd       = r_rd;
        o_q_pop    = 1'b0;
        o_res_push = 1'b0;
        src_we     = 1'b0;
        src_re     = 1'b0;
        src_ra     = r_src_s;
        hist_re    = 1'b0;
        hist_ra    = r_src_h;

        unique case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_rd    = '0;
                    unique case (e_cmd)
                        CMD_LOAD: begin
                            src_we  = 1'b1;
                            n_state = B_RESULT;
                        end
                        CMD_READ: begin
                            hist_re = 1'b1;
                            hist_ra = HAW'(e_addr);
                            n_state = B_RDWAIT;
                        end
                        CMD_LITERAL, CMD_MATCH: begin
                            n_is_match = (e_cmd == CMD_MATCH);
                            n_wp       = wp_next;
                            n_cnt      = e_len;
                            n_dst      = r_wp;
                            n_src_s    = SAW'(e_addr);
                            n_src_h    = match_src;
                            n_state    = (e_len == '0) ? B_RESULT : B_COPY;
                        end
                    endcase
                end
            end
            B_COPY: begin
                if (r_is_match) begin
                    hist_re = 1'b1;
                end else begin
                    src_re = 1'b1;
                end
                n_src_s = inc_s(r_src_s);
                n_src_h = inc_h(r_src_h);
                n_dst   = inc_h(r_dst);
                n_cnt   = r_cnt - 1'b1;
                n_wv    = 1'b1;
                n_wa    = r_dst;
                if (r_cnt == FIELD_W'(1)) begin
                    n_state = B_DRAIN;
                end
            end
            B_DRAIN: begin
                n_state = B_RESULT;
            end
            B_RDWAIT: begin
                n_rd    = hist_q;
                n_state = B_RESULT;
            end
            B_RESULT: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase

        n_fwd   = hist_re && r_wv && (hist_ra == r_wa);
        n_fwd_d = hist_wd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_wp    <= '0;
            r_wv    <= 1'b0;
            r_fwd   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_wv    <= n_wv;
            r_fwd   <= n_fwd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_match <= n_is_match;
        r_src_s    <= n_src_s;
        r_src_h    <= n_src_h;
        r_dst      <= n_dst;
        r_cnt      <= n_cnt;
        r_wa       <= n_wa;
        r_fwd_d    <= n_fwd_d;
        r_rd       <= n_rd;
    end

    lzc_ram #(
        .WIDTH (ELEMENT_BITS),
        .DEPTH (SOURCE_DEPTH)
    ) u_source_ram (
        .i_clk (i_clk),
        .i_we  (src_we),
        .i_wa  (SAW'(e_addr)),
        .i_wd  (e_data),
        .i_re  (src_re),
        .i_ra  (src_ra),
        .o_rd  (src_q)
    );

    lzc_ram #(
        .WIDTH (ELEMENT_BITS),
        .DEPTH (HISTORY_DEPTH)
    ) u_history_ram (
        .i_clk (i_clk),
        .i_we  (r_wv),
        .i_wa  (r_wa),
        .i_wd  (hist_wd),
        .i_re  (hist_re),
        .i_ra  (hist_ra),
        .o_rd  (hist_q)
    );

endmodule

`default_nettype wire

FILE: rtl/lzc_chk.sv
`default_nettype none

`include "lz_literal_match_copy_engine_core_macros.svh"

module lzc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [7:0]  o_read_data,
    input logic [15:0] o_write_pos
);

    `LZC_ASSERT_AFTER_RESET(a_reset_empty, i_clk, i_rst_n, empty,
                            "result queue not empty after reset")
    `LZC_ASSERT_AFTER_RESET(a_reset_ready, i_clk, i_rst_n, !full,
                            "command side not ready after reset")
    `LZC_ASSERT_NEXT(a_result_kept, i_clk, i_rst_n, !empty && !pop, !empty,
                     "waiting result lost")
    `LZC_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, !empty && !pop,
                     $stable(o_read_data) && $stable(o_write_pos), "waiting result changed")

endmodule

bind lz_literal_match_copy_engine_core lzc_chk u_lzc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .o_read_data (o_read_data),
    .o_write_pos (o_write_pos)
);

`default_nettype wire

FILE: test/tb_lz_literal_match_copy_engine_core.sv
`timescale 1ns / 1ps

module tb_lz_literal_match_copy_engine_core;
    import lzc_pkg::*;

    localparam int STALL_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 32;
    localparam int SHOWN_ERRORS = 10;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [15:0] write_pos;
    } t_copy_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [1:0]  i_cmd;
    logic [15:0] i_addr;
    logic [7:0]  i_data;
    logic [15:0] i_copy_length;
    logic [15:0] i_match_offset;
    logic        empty;
    logic        pop;
    logic [7:0]  o_read_data;
    logic [15:0] o_write_pos;

    // Shadow copy of the engine state.
    logic [7:0]  src_mem [0:65535];
    logic [7:0]  hist_mem [0:65535];
    logic [15:0] wr_ptr;
    bit          src_written [0:65535];
    logic [15:0] src_addrs[$];
    logic [15:0] last_load_addr;

    t_copy_result pending_results[$];

    bit tx_idle_en;
    bit rx_idle_en;
    int fail_count;
    int results_checked;
    int cmd_count [4];
    longint elements_copied;
    int stall_cycles;

    lz_literal_match_copy_engine_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_cmd          (i_cmd),
        .i_addr         (i_addr),
        .i_data         (i_data),
        .i_copy_length  (i_copy_length),
        .i_match_offset (i_match_offset),
        .empty          (empty),
        .pop            (pop),
        .o_read_data    (o_read_data),
        .o_write_pos    (o_write_pos)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_copy_result apply_command(input t_cmd c, input logic [15:0] addr,
                                                   input logic [7:0] data,
                                                   input logic [15:0] len,
                                                   input logic [15:0] off);
        t_copy_result r;
        logic [15:0]  d;
        int           k;
        r.read_data = '0;
        case (c)
            CMD_LOAD: begin
                src_mem[addr] = data;
            end
            CMD_LITERAL: begin
                for (k = 0; k < len; k++) begin
                    d = wr_ptr + 16'(k);
                    hist_mem[d] = src_mem[addr + 16'(k)];
                end
                wr_ptr = wr_ptr + len;
            end
            CMD_MATCH: begin
                // Element by element, so an offset shorter than the length
                // re-reads elements written earlier in the same copy.
                for (k = 0; k < len; k++) begin
                    d = wr_ptr + 16'(k);
                    hist_mem[d] = hist_mem[d - off];
                end
                wr_ptr = wr_ptr + len;
            end
            default: begin
                r.read_data = hist_mem[addr];
            end
        endcase
        r.write_pos = wr_ptr;
        return r;
    endfunction

    task automatic send_cmd(input t_cmd c, input logic [15:0] addr, input logic [7:0] data,
                            input logic [15:0] len, input logic [15:0] off);
        @(negedge i_clk);
        while (tx_idle_en && $urandom_range(99, 0) < 12) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push           <= 1'b1;
        i_cmd          <= c;
        i_addr         <= addr;
        i_data         <= data;
        i_copy_length  <= len;
        i_match_offset <= off;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        pending_results = {pending_results, apply_command(c, addr, data, len, off)};
        cmd_count[c]++;
        if (c == CMD_LOAD) begin
            src_written[addr] = 1'b1;
            src_addrs = {src_addrs, addr};
            last_load_addr = addr;
        end else if (c != CMD_READ) begin
            elements_copied += len;
        end
    endtask

    function automatic logic [15:0] pick_copy_length();
        int p;
        p = $urandom_range(99, 0);
        if (p < 85) begin
            return 16'($urandom_range(24, 0));
        end else if (p < 97) begin
            return 16'($urandom_range(300, 25));
        end
        return 16'($urandom_range(4000, 301));
    endfunction

    // Assumes the whole history has been written, so any match or read is legal.
    task automatic send_random_item();
        int          p;
        int          run;
        int          cap;
        logic [15:0] a;
        logic [15:0] off;
        p = $urandom_range(99, 0);
        if (p < 30) begin
            a = ($urandom_range(99, 0) < 70) ? last_load_addr + 16'd1 : 16'($urandom);
            send_cmd(CMD_LOAD, a, 8'($urandom), 16'($urandom), 16'($urandom));
        end else if (p < 55) begin
            // Start at a loaded address and stop before the first unloaded one.
            a   = src_addrs[$urandom_range(src_addrs.size() - 1, 0)];
            cap = pick_copy_length();
            run = 0;
            while (run < cap && src_written[a + 16'(run)]) begin
                run++;
            end
            send_cmd(CMD_LITERAL, a, 8'($urandom), 16'(run), 16'($urandom));
        end else if (p < 80) begin
            p = $urandom_range(99, 0);
            if (p < 50) begin
                off = 16'($urandom_range(32, 1));
            end else if (p < 80) begin
                off = 16'($urandom_range(4096, 33));
            end else if (p < 95) begin
                off = 16'($urandom);
            end else begin
                off = 16'd0;
            end
            send_cmd(CMD_MATCH, 16'($urandom), 8'($urandom), pick_copy_length(), off);
        end else begin
            if ($urandom_range(99, 0) < 60) begin
                a = wr_ptr - 16'($urandom_range(64, 1));
            end else begin
                a = 16'($urandom);
            end
            send_cmd(CMD_READ, a, 8'($urandom), 16'($urandom), 16'($urandom));
        end
    endtask

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= SHOWN_ERRORS) begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
    endtask

    // Result side: pop drops at random while rx_idle_en is set, else stays high.
    initial begin
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            pop <= !rx_idle_en || ($urandom_range(99, 0) >= 12);
        end
    end

    always @(posedge i_clk) begin
        t_copy_result want;
        if (i_rst_n && pop && !empty) begin
            if (pending_results.size() == 0) begin
                note_failure($sformatf("unexpected result read_data=%02h write_pos=%04h",
                                       o_read_data, o_write_pos));
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (o_read_data !== want.read_data || o_write_pos !== want.write_pos) begin
                    note_failure($sformatf(
                        "result %0d: read_data exp %02h got %02h, write_pos exp %04h got %04h",
                        results_checked, want.read_data, o_read_data, want.write_pos,
                        o_write_pos));
                end
            end
        end
    end

    // Any beat on either side restarts the count.
    initial begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("ERROR: no beat for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, pending_results.size());
        $display("Test completed with failures");
        $finish;
    end

    task automatic test_source_wrap_literal();
        send_cmd(CMD_LOAD, 16'hFFFD, 8'h00, 16'hFFFF, 16'hFFFF);
        send_cmd(CMD_LOAD, 16'hFFFE, 8'hFF, 16'h0000, 16'h0000);
        send_cmd(CMD_LOAD, 16'hFFFF, 8'hA5, 16'h5555, 16'hAAAA);
        send_cmd(CMD_LOAD, 16'h0000, 8'h5A, 16'hAAAA, 16'h5555);
        send_cmd(CMD_LOAD, 16'h0001, 8'h01, 16'h0000, 16'h0000);
        send_cmd(CMD_LOAD, 16'h0002, 8'h80, 16'h0000, 16'h0000);
        send_cmd(CMD_LOAD, 16'h0003, 8'h7E, 16'h0000, 16'h0000);
        // Starts two elements below the top of the source memory and wraps.
        send_cmd(CMD_LITERAL, 16'hFFFD, 8'h00, 16'd7, 16'd0);
        send_cmd(CMD_LITERAL, 16'h0001, 8'hFF, 16'd0, 16'hFFFF);
    endtask

    task automatic test_history_fill();
        // Offset one with the longest length repeats the last element around
        // the whole history, so every entry is written from here on.
        send_cmd(CMD_MATCH, 16'h0000, 8'h00, 16'hFFFF, 16'd1);
    endtask

    task automatic test_match_corners();
        send_cmd(CMD_READ, 16'h0000, 8'h00, 16'h0000, 16'h0000);
        send_cmd(CMD_READ, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF);
        send_cmd(CMD_READ, wr_ptr, 8'h00, 16'h0000, 16'h0000);
        send_cmd(CMD_MATCH, 16'h0000, 8'h00, 16'd0, 16'd9);
        send_cmd(CMD_MATCH, 16'h0000, 8'h00, 16'd5, 16'd0);
        send_cmd(CMD_MATCH, 16'hFFFF, 8'h00, 16'd6, 16'hFFFF);
        send_cmd(CMD_MATCH, 16'h0000, 8'h00, 16'd10, 16'd3);
        send_cmd(CMD_MATCH, 16'h0000, 8'h00, 16'd5, 16'd20);
        send_cmd(CMD_READ, wr_ptr - 16'd1, 8'h00, 16'h0000, 16'h0000);
        send_cmd(CMD_READ, wr_ptr - 16'd10, 8'h00, 16'h0000, 16'h0000);
        send_cmd(CMD_READ, wr_ptr - 16'd15, 8'h00, 16'h0000, 16'h0000);
    endtask

    task automatic test_random_mix(input int n);
        repeat (n) begin
            send_random_item();
        end
    endtask

    task automatic test_back_to_back(input int n);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        repeat (n) begin
            send_random_item();
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    initial begin
        i_rst_n        = 1'b0;
        push           = 1'b0;
        i_cmd          = CMD_LOAD;
        i_addr         = '0;
        i_data         = '0;
        i_copy_length  = '0;
        i_match_offset = '0;
        wr_ptr         = '0;
        last_load_addr = '0;
        tx_idle_en     = 1'b1;
        rx_idle_en     = 1'b1;
        fail_count     = 0;
        results_checked = 0;
        elements_copied = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_source_wrap_literal();
        test_history_fill();
        test_match_corners();
        test_random_mix(300);
        test_back_to_back(150);
        test_random_mix(300);

        @(negedge i_clk);
        push <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d loads, %0d literal copies, %0d match copies and %0d reads.",
                 cmd_count[CMD_LOAD], cmd_count[CMD_LITERAL], cmd_count[CMD_MATCH],
                 cmd_count[CMD_READ]);
        $display("Moved %0d elements in all; %0d results checked, %0d failures.",
                 elements_copied, results_checked, fail_count);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/lzc_pkg.sv
rtl/lzc_ram.sv
rtl/lzc_fifo.sv
rtl/lzc_front.sv
rtl/lzc_back.sv
rtl/lz_literal_match_copy_engine_core.sv
rtl/lzc_chk.sv
test/tb_lz_literal_match_copy_engine_core.sv
